@@ sv/rmq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types for the matrix-to-quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // which quaternion part takes the half root
  typedef enum logic [1:0] {
    PIV_TRACE = 2'd0,
    PIV_X     = 2'd1,
    PIV_Y     = 2'd2,
    PIV_Z     = 2'd3
  } pivot_e;

  // per-cell pipeline control
  typedef struct packed {
    logic en;
    logic valid;
  } cell_ctl_t;

endpackage

@@ sv/rmq_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_mat_if / rmq_quat_if
// Valid/ready channels for matrix requests and quaternion results.
// ----------------------------------------------------------------------------
interface rmq_mat_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] m00;
  logic signed [DATA_WIDTH-1:0] m01;
  logic signed [DATA_WIDTH-1:0] m02;
  logic signed [DATA_WIDTH-1:0] m10;
  logic signed [DATA_WIDTH-1:0] m11;
  logic signed [DATA_WIDTH-1:0] m12;
  logic signed [DATA_WIDTH-1:0] m20;
  logic signed [DATA_WIDTH-1:0] m21;
  logic signed [DATA_WIDTH-1:0] m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

interface rmq_quat_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] quat_w;
  logic signed [DATA_WIDTH-1:0] quat_x;
  logic signed [DATA_WIDTH-1:0] quat_y;
  logic signed [DATA_WIDTH-1:0] quat_z;
  logic                         root_zero;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, root_zero,
                  input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, root_zero,
                output ready);
endinterface

@@ sv/rmq_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// One digit of a restoring integer square root; one result bit per cell.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell import rmq_pkg::*; #(
  parameter int SQW = 32,
  parameter int RW  = 16,
  parameter int MW  = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctl_t       ctl_i,
  input  logic [SQW-1:0]  rad_i,
  input  logic [RW+1:0]   rem_i,
  input  logic [RW-1:0]   root_i,
  input  logic [MW-1:0]   meta_i,
  output logic            valid_o,
  output logic [SQW-1:0]  rad_o,
  output logic [RW+1:0]   rem_o,
  output logic [RW-1:0]   root_o,
  output logic [MW-1:0]   meta_o
);

  logic [RW+3:0]  tmp;
  logic [RW+3:0]  trial;
  logic           ge;
  logic [RW+1:0]  rem_d;
  logic [RW-1:0]  root_d;
  logic           valid_q;
  logic [SQW-1:0] rad_q;
  logic [RW+1:0]  rem_q;
  logic [RW-1:0]  root_q;
  logic [MW-1:0]  meta_q;

  always_comb begin
    tmp    = {rem_i, rad_i[SQW-1 -: 2]};
    trial  = (RW+4)'({root_i, 2'b01});
    ge     = (tmp >= trial);
    rem_d  = ge ? (RW+2)'(tmp - trial) : (RW+2)'(tmp);
    root_d = {root_i[RW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.en) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      rad_q  <= rad_i << 2;
      rem_q  <= rem_d;
      root_q <= root_d;
      meta_q <= meta_i;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign meta_o  = meta_q;

endmodule

@@ sv/rmq_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div_cell
// One restoring division step for three lanes sharing one divisor.
// ----------------------------------------------------------------------------
module rmq_div_cell import rmq_pkg::*; #(
  parameter int NW  = 31,
  parameter int DVW = 17,
  parameter int MW  = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctl_t       ctl_i,
  input  logic [DVW-1:0]  div_i,
  input  logic [NW-1:0]   num_i [3],
  input  logic [DVW-1:0]  rem_i [3],
  input  logic [MW-1:0]   meta_i,
  output logic            valid_o,
  output logic [DVW-1:0]  div_o,
  output logic [NW-1:0]   num_o [3],
  output logic [DVW-1:0]  rem_o [3],
  output logic [MW-1:0]   meta_o
);

  logic [DVW:0]   tmp   [3];
  logic           ge    [3];
  logic [DVW-1:0] rem_d [3];
  logic [NW-1:0]  num_d [3];
  logic           valid_q;
  logic [DVW-1:0] div_q;
  logic [NW-1:0]  num_q [3];
  logic [DVW-1:0] rem_q [3];
  logic [MW-1:0]  meta_q;

  // numerator shifts out at the top, quotient bits shift in at the bottom
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      tmp[l]   = {rem_i[l], num_i[l][NW-1]};
      ge[l]    = (tmp[l] >= {1'b0, div_i});
      rem_d[l] = ge[l] ? DVW'(tmp[l] - {1'b0, div_i}) : DVW'(tmp[l]);
      num_d[l] = {num_i[l][NW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.en) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      div_q  <= div_i;
      num_q  <= num_d;
      rem_q  <= rem_d;
      meta_q <= meta_i;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;
  assign num_o   = num_q;
  assign rem_o   = rem_q;
  assign meta_o  = meta_q;

endmodule

@@ sv/rotation_matrix_to_quaternion.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a fixed-point 3x3 rotation matrix to a quaternion.
// ----------------------------------------------------------------------------
// Takes one matrix request per cycle and returns one quaternion per request,
// in order. The pipeline has one input stage that picks the pivot and forms
// the root argument, RW square-root cells (one root bit each), NW division
// cells (one quotient bit each, three lanes sharing the divisor 2r), and the
// output register. The whole chain advances whenever the output register is
// empty or being taken, so a held result stalls the chain and the input with
// it; mat_i.ready follows quat_o.ready combinationally while a result is held.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  rmq_mat_if.sink    mat_i,
  rmq_quat_if.source quat_o
);

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int AW  = ((W > F) ? W : F + 1) + 3;
  localparam int SQW = ((AW - 1 + F) % 2 == 0) ? (AW - 1 + F) : (AW + F);
  localparam int RW  = SQW / 2;
  localparam int DW  = W + 1;
  localparam int NW  = DW + F;
  localparam int DVW = RW + 1;
  localparam int MW1 = 2 + 3 + 3 * NW;
  localparam int MW2 = 2 + 3 + RW;
  localparam logic [NW-1:0] QMAX = NW'((64'd1 << (W - 1)) - 64'd1);

  typedef struct packed {
    logic [1:0]    piv;
    logic [2:0]    sgn;
    logic [NW-1:0] n2;
    logic [NW-1:0] n1;
    logic [NW-1:0] n0;
  } sq_meta_t;

  typedef struct packed {
    logic [1:0]    piv;
    logic [2:0]    sgn;
    logic [RW-1:0] root;
  } dv_meta_t;

  function automatic logic [W-1:0] sat(input logic [NW-1:0] q, input logic neg);
    logic [W-1:0] r;
    if (neg) begin
      r = (q > QMAX + NW'(1)) ? {1'b1, {(W-1){1'b0}}} : W'(NW'(0) - q);
    end else begin
      r = (q > QMAX) ? {1'b0, {(W-1){1'b1}}} : W'(q);
    end
    return r;
  endfunction

  logic en;

  // input stage
  logic signed [AW-1:0] e00, e11, e22, tr, arg, dii, djj, dkk;
  logic signed [DW-1:0] dl [3];
  logic [DW-1:0]        mag [3];
  pivot_e               piv;
  logic                 s0_vld_q;
  logic [SQW-1:0]       s0_rad_q;
  sq_meta_t             s0_meta_q;
  sq_meta_t             s0_meta_d;

  always_comb begin
    e00 = AW'(mat_i.m00);
    e11 = AW'(mat_i.m11);
    e22 = AW'(mat_i.m22);
    tr  = e00 + e11 + e22;
    dii = e00;
    djj = e11;
    dkk = e22;
    if (tr > 0) begin
      piv   = PIV_TRACE;
      dl[0] = DW'(mat_i.m12) - DW'(mat_i.m21);
      dl[1] = DW'(mat_i.m20) - DW'(mat_i.m02);
      dl[2] = DW'(mat_i.m01) - DW'(mat_i.m10);
    end else if (e22 > ((e11 > e00) ? e11 : e00)) begin
      piv   = PIV_Z;
      dii   = e22;
      djj   = e00;
      dkk   = e11;
      dl[0] = DW'(mat_i.m01) - DW'(mat_i.m10);
      dl[1] = DW'(mat_i.m20) + DW'(mat_i.m02);
      dl[2] = DW'(mat_i.m21) + DW'(mat_i.m12);
    end else if (e11 > e00) begin
      piv   = PIV_Y;
      dii   = e11;
      djj   = e22;
      dkk   = e00;
      dl[0] = DW'(mat_i.m20) - DW'(mat_i.m02);
      dl[1] = DW'(mat_i.m12) + DW'(mat_i.m21);
      dl[2] = DW'(mat_i.m10) + DW'(mat_i.m01);
    end else begin
      piv   = PIV_X;
      dl[0] = DW'(mat_i.m12) - DW'(mat_i.m21);
      dl[1] = DW'(mat_i.m01) + DW'(mat_i.m10);
      dl[2] = DW'(mat_i.m02) + DW'(mat_i.m20);
    end
    if (piv == PIV_TRACE) begin
      arg = tr + (AW'(1) <<< F);
    end else begin
      arg = dii - (djj + dkk) + (AW'(1) <<< F);
    end
    for (int l = 0; l < 3; l++) begin
      mag[l] = dl[l][DW-1] ? DW'(-dl[l]) : DW'(dl[l]);
    end
    s0_meta_d.piv = piv;
    s0_meta_d.sgn = {dl[2][DW-1], dl[1][DW-1], dl[0][DW-1]};
    s0_meta_d.n0  = NW'(mag[0]) << F;
    s0_meta_d.n1  = NW'(mag[1]) << F;
    s0_meta_d.n2  = NW'(mag[2]) << F;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= mat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // negative or zero argument clamps to a zero radicand
      s0_rad_q  <= (arg > 0) ? (SQW'(arg[AW-2:0]) << F) : '0;
      s0_meta_q <= s0_meta_d;
    end
  end

  // square-root chain
  logic           sq_vld  [RW+1];
  logic [SQW-1:0] sq_rad  [RW+1];
  logic [RW+1:0]  sq_rem  [RW+1];
  logic [RW-1:0]  sq_root [RW+1];
  logic [MW1-1:0] sq_meta [RW+1];

  assign sq_vld[0]  = s0_vld_q;
  assign sq_rad[0]  = s0_rad_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_meta[0] = s0_meta_q;

  for (genvar k = 0; k < RW; k++) begin : g_sq
    rmq_sqrt_cell #(.SQW(SQW), .RW(RW), .MW(MW1)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  ('{en: en, valid: sq_vld[k]}),
      .rad_i  (sq_rad[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .meta_i (sq_meta[k]),
      .valid_o(sq_vld[k+1]),
      .rad_o  (sq_rad[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .meta_o (sq_meta[k+1])
    );
  end

  // division chain
  sq_meta_t       sq_last;
  dv_meta_t       dv_first;
  logic           dv_vld  [NW+1];
  logic [DVW-1:0] dv_div  [NW+1];
  logic [NW-1:0]  dv_num  [NW+1][3];
  logic [DVW-1:0] dv_rem  [NW+1][3];
  logic [MW2-1:0] dv_meta [NW+1];

  always_comb begin
    sq_last       = sq_meta[RW];
    dv_first.piv  = sq_last.piv;
    dv_first.sgn  = sq_last.sgn;
    dv_first.root = sq_root[RW];
  end

  assign dv_vld[0]    = sq_vld[RW];
  assign dv_div[0]    = {sq_root[RW], 1'b0};
  assign dv_num[0][0] = sq_last.n0;
  assign dv_num[0][1] = sq_last.n1;
  assign dv_num[0][2] = sq_last.n2;
  assign dv_rem[0][0] = '0;
  assign dv_rem[0][1] = '0;
  assign dv_rem[0][2] = '0;
  assign dv_meta[0]   = dv_first;

  for (genvar k = 0; k < NW; k++) begin : g_dv
    rmq_div_cell #(.NW(NW), .DVW(DVW), .MW(MW2)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  ('{en: en, valid: dv_vld[k]}),
      .div_i  (dv_div[k]),
      .num_i  (dv_num[k]),
      .rem_i  (dv_rem[k]),
      .meta_i (dv_meta[k]),
      .valid_o(dv_vld[k+1]),
      .div_o  (dv_div[k+1]),
      .num_o  (dv_num[k+1]),
      .rem_o  (dv_rem[k+1]),
      .meta_o (dv_meta[k+1])
    );
  end

  // output stage
  dv_meta_t     dv_last;
  logic [W-1:0] half, l0, l1, l2;
  logic [W-1:0] w_d, x_d, y_d, z_d;
  logic         zero_d;
  logic         o_vld_q;
  logic [W-1:0] w_q, x_q, y_q, z_q;
  logic         zero_q;

  always_comb begin
    dv_last = dv_meta[NW];
    half    = sat(NW'(dv_last.root >> 1), 1'b0);
    l0      = sat(dv_num[NW][0], dv_last.sgn[0]);
    l1      = sat(dv_num[NW][1], dv_last.sgn[1]);
    l2      = sat(dv_num[NW][2], dv_last.sgn[2]);
    zero_d  = (dv_last.root == '0);
    unique case (pivot_e'(dv_last.piv))
      PIV_TRACE: begin w_d = half; x_d = l0;   y_d = l1;   z_d = l2;   end
      PIV_X:     begin w_d = l0;   x_d = half; y_d = l1;   z_d = l2;   end
      PIV_Y:     begin w_d = l0;   x_d = l2;   y_d = half; z_d = l1;   end
      PIV_Z:     begin w_d = l0;   x_d = l1;   y_d = l2;   z_d = half; end
      default:   begin w_d = '0;   x_d = '0;   y_d = '0;   z_d = '0;   end
    endcase
    if (zero_d) begin
      w_d = '0;
      x_d = '0;
      y_d = '0;
      z_d = '0;
    end
  end

  assign en = !o_vld_q || quat_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (en) begin
      o_vld_q <= dv_vld[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q    <= w_d;
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      zero_q <= zero_d;
    end
  end

  assign mat_i.ready      = en;
  assign quat_o.valid     = o_vld_q;
  assign quat_o.quat_w    = w_q;
  assign quat_o.quat_x    = x_q;
  assign quat_o.quat_y    = y_q;
  assign quat_o.quat_z    = z_q;
  assign quat_o.root_zero = zero_q;

endmodule
